[rtl/core/assert_macros.svh]
// Assertion macros used by the back end of the seven-segment encoder.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that a condition implies another one in the following cycle.
`define ASSERT_NEXT(lbl, clk, rst, cond, nxt, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (nxt)) else $error(msg);

`endif

[rtl/core/dsse_pkg.sv]
// Types, constants and the segment table of the seven-segment encoder.
`timescale 1ns / 1ps

package dsse_pkg;

  // Input range and display layout
  localparam logic [13:0] ValueMax  = 14'd9999;
  localparam logic [13:0] ModeSplit = 14'd1000;
  localparam logic [7:0]  PointBit  = 8'h02;

  // Reciprocals for division by constants: floor(x * R >> S)
  localparam logic [12:0] Recip100 = 13'd5243;  // exact for x < 43699, shift 19
  localparam int          Shift100 = 19;
  localparam logic [7:0]  Recip10  = 8'd205;    // exact for x < 1029, shift 11
  localparam int          Shift10  = 11;

  // Digit queue
  localparam int QueueDepth = 4;
  localparam int PtrW       = $clog2(QueueDepth);
  localparam int CountW     = $clog2(QueueDepth + 1);

  // Digit positions
  localparam logic [1:0] PosFirst = 2'd0;
  localparam logic [1:0] PosLast  = 2'd2;

  // Three segment bytes, index 0 is the leftmost digit
  typedef logic [2:0][7:0] dsse_entry_t;

  // One queue port: an entry and its valid flag
  typedef struct packed {
    logic        valid;
    dsse_entry_t entry;
  } dsse_link_t;

  // Segment pattern of one decimal digit, digits above nine show as nine
  function automatic logic [7:0] seg_of(input logic [3:0] digit);
    logic [7:0] pat;
    case (digit)
      4'd0:    pat = 8'b11110101;
      4'd1:    pat = 8'b00010100;
      4'd2:    pat = 8'b11011001;
      4'd3:    pat = 8'b01011101;
      4'd4:    pat = 8'b00111100;
      4'd5:    pat = 8'b01101101;
      4'd6:    pat = 8'b11101101;
      4'd7:    pat = 8'b01010100;
      4'd8:    pat = 8'b11111101;
      default: pat = 8'b01111101;
    endcase
    return pat;
  endfunction

endpackage

[rtl/core/dsse_front.sv]
// Front pipeline: saturates the value, splits it into digits and forms segment bytes.
`timescale 1ns / 1ps

module dsse_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [13:0]         value,
  input  logic                queue_full,
  output dsse_pkg::dsse_link_t push
);

  logic [13:0] v_sat;
  logic [26:0] prod100;
  logic        s1_valid, s2_valid, s3_valid;
  logic [13:0] s1_v;
  logic [6:0]  s1_whole;
  logic        s1_mode, s2_mode, s3_mode;
  logic [6:0]  s2_whole, s2_frac, s3_whole, s3_frac;
  logic [6:0]  frac_calc;
  logic [14:0] prod_w, prod_f;
  logic [3:0]  s3_tens_w, s3_tens_f;
  logic [3:0]  ones_w, ones_f;
  logic [6:0]  tens_w_x10, tens_f_x10;
  logic [3:0]  d0, d1, d2;
  logic        advance;

  // Whole pipeline moves when its last stage is empty or the queue has room
  assign advance  = !s3_valid || !queue_full;
  assign in_ready = advance;

  // Stage one: saturate and divide by one hundred
  assign v_sat   = (value > dsse_pkg::ValueMax) ? dsse_pkg::ValueMax : value;
  assign prod100 = 27'(v_sat) * 27'(dsse_pkg::Recip100);

  // Stage two: remainder by one hundred, whole * 100 as shifts
  assign frac_calc = 7'(s1_v - ({7'd0, s1_whole} << 6) - ({7'd0, s1_whole} << 5)
                        - ({7'd0, s1_whole} << 2));

  // Stage three input: tens of whole and fraction
  assign prod_w = 15'(s2_whole) * 15'(dsse_pkg::Recip10);
  assign prod_f = 15'(s2_frac) * 15'(dsse_pkg::Recip10);

  // Valid flags
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else if (advance) begin
      s1_valid <= in_valid;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
    end
  end

  // Payload stages
  always_ff @(posedge clk) begin
    if (advance) begin
      s1_v      <= v_sat;
      s1_whole  <= prod100[dsse_pkg::Shift100 +: 7];
      s1_mode   <= (v_sat >= dsse_pkg::ModeSplit);
      s2_whole  <= s1_whole;
      s2_frac   <= frac_calc;
      s2_mode   <= s1_mode;
      s3_whole  <= s2_whole;
      s3_frac   <= s2_frac;
      s3_mode   <= s2_mode;
      s3_tens_w <= prod_w[dsse_pkg::Shift10 +: 4];
      s3_tens_f <= prod_f[dsse_pkg::Shift10 +: 4];
    end
  end

  // Ones digits and layout selection
  assign tens_w_x10 = ({3'd0, s3_tens_w} << 3) + ({3'd0, s3_tens_w} << 1);
  assign tens_f_x10 = ({3'd0, s3_tens_f} << 3) + ({3'd0, s3_tens_f} << 1);
  assign ones_w     = 4'(s3_whole - tens_w_x10);
  assign ones_f     = 4'(s3_frac - tens_f_x10);

  always_comb begin
    if (s3_mode) begin
      d0 = s3_tens_w;
      d1 = ones_w;
      d2 = s3_tens_f;
    end else begin
      d0 = ones_w;
      d1 = s3_tens_f;
      d2 = ones_f;
    end
  end

  // Segment bytes with the decimal point on the first or second digit
  always_comb begin
    push.valid    = s3_valid && !queue_full;
    push.entry[0] = dsse_pkg::seg_of(d0) | (s3_mode ? 8'h00 : dsse_pkg::PointBit);
    push.entry[1] = dsse_pkg::seg_of(d1) | (s3_mode ? dsse_pkg::PointBit : 8'h00);
    push.entry[2] = dsse_pkg::seg_of(d2);
  end

endmodule

[rtl/core/dsse_queue.sv]
// Short register queue of segment-byte entries between front and back.
`timescale 1ns / 1ps

module dsse_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  dsse_pkg::dsse_link_t push,
  output logic                 full,
  input  logic                 pop,
  output dsse_pkg::dsse_link_t head
);

  dsse_pkg::dsse_entry_t mem [dsse_pkg::QueueDepth];
  logic [dsse_pkg::PtrW-1:0]   wr_ptr, rd_ptr;
  logic [dsse_pkg::CountW-1:0] count;
  logic                        do_pop;

  assign full       = (count == dsse_pkg::CountW'(dsse_pkg::QueueDepth));
  assign head.valid = (count != '0);
  assign head.entry = mem[rd_ptr];
  assign do_pop     = pop && head.valid;

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push.valid) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop) rd_ptr <= rd_ptr + 1'b1;
      count <= count + dsse_pkg::CountW'(push.valid) - dsse_pkg::CountW'(do_pop);
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (push.valid) begin
      mem[wr_ptr] <= push.entry;
    end
  end

endmodule

[rtl/core/dsse_back.sv]
// Back end: sends the three digits of each queued entry, one per cycle while out_ready is high.
`timescale 1ns / 1ps

`include "assert_macros.svh"

module dsse_back (
  input  logic                 clk,
  input  logic                 rst,
  input  dsse_pkg::dsse_link_t head,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [1:0]           position,
  output logic [7:0]           pattern,
  output logic                 last
);

  dsse_pkg::dsse_entry_t pats;
  logic                  take;
  logic                  more;

  assign take = !out_valid || out_ready;
  assign more = out_valid && (position != dsse_pkg::PosLast);
  assign pop  = take && !more && head.valid;

  // Output register: step through the digits, then load the next entry
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      position  <= dsse_pkg::PosFirst;
    end else if (take) begin
      if (more) begin
        position <= position + 1'b1;
      end else if (head.valid) begin
        out_valid <= 1'b1;
        position  <= dsse_pkg::PosFirst;
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      pats <= head.entry;
    end
  end

  assign pattern = pats[position];
  assign last    = (position == dsse_pkg::PosLast);

  // Checks
  `ASSERT_CLK(a_pos_range, clk, rst, position != 2'd3, "digit position out of range")
  `ASSERT_NEXT(a_stall_hold, clk, rst, out_valid && !out_ready,
               out_valid && position == $past(position), "stalled digit changed")
  `ASSERT_NEXT(a_step, clk, rst, out_valid && out_ready && !last,
               out_valid && position == $past(position) + 2'd1, "digit skipped")

endmodule

[rtl/core/decimal_seven_segment_encoder.sv]
// Top level of the decimal seven-segment encoder.
// Usage:
//   Slave stream s_*: one item per displayed value, s_tdata[13:0] holds the
//   value in hundredths; values above 9999 show as 99.9.
//   Master stream m_*: three items per value, leftmost digit first. Each
//   carries the digit position and its segment byte (bit 1 decimal point);
//   m_tlast marks the third digit.
//   A value passes the three front stages, the queue and then the output
//   register before its first digit shows on m_*.
//   The back end sends one digit per cycle while m_tready is high, which
//   sets the value rate; the front takes one value per cycle until its
//   four-entry queue fills.
//   Reset (rst, synchronous) empties the pipeline, queue and output register.
//   When m_tready is low the current digit holds; the queue and then the
//   front pipeline fill, and s_tready drops once the queue is full and the
//   last front stage holds a value.
`timescale 1ns / 1ps

module decimal_seven_segment_encoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [13:0] value_hundredths, [15:14] zero
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [1:0] digit_position, [9:2] segment_pattern, [15:10] zero
  output logic        m_tlast
);

  dsse_pkg::dsse_link_t push, head;
  logic                 queue_full;
  logic                 pop;
  logic [1:0]           position;
  logic [7:0]           pattern;

  dsse_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .value      (s_tdata[13:0]),
    .queue_full (queue_full),
    .push       (push)
  );

  dsse_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .full (queue_full),
    .pop  (pop),
    .head (head)
  );

  dsse_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .pop       (pop),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .position  (position),
    .pattern   (pattern),
    .last      (m_tlast)
  );

  assign m_tdata = {6'd0, pattern, position};

endmodule

[tb/sv/dsse_scoreboard.sv]
// Checker for the seven-segment encoder: predicts digit items and compares them.
`timescale 1ns / 1ps

module dsse_scoreboard (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [15:0] s_tdata,   // [13:0] value_hundredths, [15:14] zero
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [15:0] m_tdata,   // [1:0] digit_position, [9:2] segment_pattern, [15:10] zero
  input  logic        m_tlast,
  output int          fail_count,
  output int          digits_due_count,
  output int          digits_checked
);

  // One displayed digit as it appears on the output stream
  typedef struct packed {
    logic [5:0] pad;
    logic [1:0] pos;
    logic [7:0] seg;
    logic       last;
  } digit_t;

  typedef digit_t [2:0] digit_trio_t;

  localparam logic [7:0] DP_MASK = 8'h02;

  // Segment glyphs, entry 0 in the lowest byte
  localparam logic [9:0][7:0] GLYPHS = {
    8'h7D, 8'hFD, 8'h54, 8'hED, 8'h6D, 8'h3C, 8'h5D, 8'hD9, 8'h14, 8'hF5
  };

  digit_t digits_due[$];

  // Split a value into its three display digits, leftmost first
  function automatic digit_trio_t encode_value(input logic [13:0] raw);
    int unsigned v, whole, frac, dig[3], dp_at;
    digit_trio_t trio;
    v = (raw > dsse_pkg::ValueMax) ? dsse_pkg::ValueMax : raw;
    whole = v / 100;
    frac  = v % 100;
    if (v < dsse_pkg::ModeSplit) begin
      dig[0] = whole % 10;
      dig[1] = frac / 10;
      dig[2] = frac % 10;
      dp_at  = 0;
    end else begin
      dig[0] = whole / 10;
      dig[1] = whole % 10;
      dig[2] = frac / 10;
      dp_at  = 1;
    end
    for (int k = 0; k < 3; k++) begin
      trio[k].pad  = '0;
      trio[k].pos  = k[1:0];
      trio[k].seg  = GLYPHS[(dig[k] > 9) ? 9 : dig[k]] | ((k == dp_at) ? DP_MASK : 8'h00);
      trio[k].last = (k == 2);
    end
    return trio;
  endfunction

  task automatic note_mismatch(input string what, input digit_t want, input digit_t got);
    fail_count++;
    if (fail_count <= 10)
      $display({"%0t mismatch (%s): want pos=%0d seg=%02h last=%0b pad=%0h,",
                " got pos=%0d seg=%02h last=%0b pad=%0h"},
               $realtime, what, want.pos, want.seg, want.last, want.pad,
               got.pos, got.seg, got.last, got.pad);
  endtask

  // Compare each accepted digit first, then queue the digits of a new value
  always @(posedge clk) begin : watch
    digit_t      got;
    digit_t      want;
    digit_trio_t trio;
    if (rst) begin
      digits_due.delete();
      fail_count       = 0;
      digits_checked   = 0;
      digits_due_count = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        got.pad  = m_tdata[15:10];
        got.pos  = m_tdata[1:0];
        got.seg  = m_tdata[9:2];
        got.last = m_tlast;
        digits_checked++;
        if (digits_due.size() == 0) begin
          note_mismatch("unexpected item", '0, got);
        end else begin
          want = digits_due.pop_front();
          if (got !== want)
            note_mismatch("field", want, got);
        end
      end
      if (s_tvalid && s_tready) begin
        trio = encode_value(s_tdata[13:0]);
        for (int k = 0; k < 3; k++)
          digits_due.push_back(trio[k]);
      end
      digits_due_count = digits_due.size();
    end
  end

endmodule

[tb/sv/tb.sv]
// Testbench top: stimulus, flow control and verdict for the seven-segment encoder.
`timescale 1ns / 1ps

module tb;

  localparam int HOLD_CYCLES = 80;
  localparam int DRAIN_CYCLES = 16;
  localparam int RANDOM_PER_PHASE = 25;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;
  logic        m_tlast;

  int fail_count;
  int digits_due_count;
  int digits_checked;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_req = 0;
  int hold_ack = 0;
  int hold_left = 0;
  int values_sent = 0;
  int saturated_sent = 0;
  int below_ten_sent = 0;

  always #4 clk = ~clk;

  decimal_seven_segment_encoder dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  dsse_scoreboard checker_i (
    .clk              (clk),
    .rst              (rst),
    .s_tvalid         (s_tvalid),
    .s_tready         (s_tready),
    .s_tdata          (s_tdata),
    .m_tvalid         (m_tvalid),
    .m_tready         (m_tready),
    .m_tdata          (m_tdata),
    .m_tlast          (m_tlast),
    .fail_count       (fail_count),
    .digits_due_count (digits_due_count),
    .digits_checked   (digits_checked)
  );

  // Run limit
  initial begin
    #400000;
    $display("tb: FAIL");
    $finish;
  end

  // Receiver: long hold on request, otherwise random stalls
  always @(negedge clk) begin
    if (hold_left > 0) begin
      m_tready <= 1'b0;
      hold_left--;
    end else if (hold_req != hold_ack) begin
      hold_ack = hold_req;
      hold_left = HOLD_CYCLES - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Offer one value, with random idle cycles ahead of it; returns after its handshake
  task automatic send_value(input logic [13:0] v);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {2'b00, v};
    do @(posedge clk); while (!s_tready);
    values_sent++;
    if (v > 14'd9999) saturated_sent++;
    if (v < 14'd1000) below_ten_sent++;
  endtask

  // Mostly in-range values, with weight on the small range, the layout split and overflow
  function automatic logic [13:0] pick_value();
    case ($urandom_range(9))
      0, 1:    return 14'($urandom_range(999));
      2:       return 14'($urandom_range(1010, 990));
      3:       return 14'($urandom_range(16383, 10000));
      4:       return 14'($urandom_range(9999, 9900));
      default: return 14'($urandom_range(9999));
    endcase
  endfunction

  initial begin
    logic [13:0] directed[$];
    directed = '{14'd0, 14'd1, 14'd9, 14'd10, 14'd99, 14'd100, 14'd999, 14'd1000,
                 14'd1001, 14'd1234, 14'd5678, 14'd9090, 14'd4567, 14'd8765,
                 14'd9999, 14'd10000, 14'd8191, 14'd16383, 14'h2AAA, 14'h1555,
                 14'd305, 14'd7020};

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed values, no idling
    foreach (directed[i])
      send_value(directed[i]);

    // Long receiver hold while values keep coming, then sender gaps with no receiver stalls
    hold_req++;
    for (int i = 0; i < RANDOM_PER_PHASE; i++)
      send_value(pick_value());

    send_idle_pct = 54;
    recv_stall_pct = 0;
    for (int i = 0; i < RANDOM_PER_PHASE; i++)
      send_value(pick_value());

    send_idle_pct = 0;
    recv_stall_pct = 54;
    for (int i = 0; i < RANDOM_PER_PHASE; i++)
      send_value(pick_value());

    send_idle_pct = 26;
    recv_stall_pct = 26;
    for (int i = 0; i < RANDOM_PER_PHASE; i++)
      send_value(pick_value());

    @(negedge clk);
    s_tvalid <= 1'b0;

    // Drain outstanding digits, then watch for strays
    while (digits_due_count != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d values (%0d below 10.00, %0d saturated) and %0d digit items,",
             values_sent, below_ten_sent, saturated_sent, digits_checked);
    $display("across idle, sender-gap, receiver-stall, mixed and long-hold flow; %0d mismatches",
             fail_count);
    if (fail_count == 0 && digits_due_count == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
